/* design/convolutional_encoder_top_defines.svh */
// ----------------------------------------------------------------------------
// Convolutional encoder assertion macros
// Shared property wrappers for the encoder checker.
// ----------------------------------------------------------------------------
`ifndef CONVOLUTIONAL_ENCODER_TOP_DEFINES_SVH
`define CONVOLUTIONAL_ENCODER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define CE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ce_pkg.sv */
// ----------------------------------------------------------------------------
// Convolutional encoder package
// Widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package ce_pkg;

  localparam int MAX_CONSTRAINT = 9;
  localparam int MAX_RATE       = 3;
  localparam int POLY_W         = 9;
  localparam int CODED_W        = 3;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 9;
  localparam int TDATA_W        = 8;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CODE_RATE   = 3'd0,
    REG_CONSTRAINT  = 3'd1,
    REG_TAIL_BITING = 3'd2,
    REG_POLY_FIRST  = 3'd3,
    REG_POLY_SECOND = 3'd4,
    REG_POLY_THIRD  = 3'd5
  } cfg_reg_t;

  localparam logic [1:0]        RST_CODE_RATE   = 2'd3;
  localparam logic [3:0]        RST_CONSTRAINT  = 4'd7;
  localparam logic              RST_TAIL_BITING = 1'b1;
  localparam logic [POLY_W-1:0] RST_POLY_FIRST  = 9'd91;
  localparam logic [POLY_W-1:0] RST_POLY_SECOND = 9'd121;
  localparam logic [POLY_W-1:0] RST_POLY_THIRD  = 9'd117;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic               last;
    logic [CODED_W-1:0] coded;
  } out_item_t;

endpackage

/* design/convolutional_encoder_top.sv */
// ----------------------------------------------------------------------------
// Convolutional encoder top level
// A data transaction's result is registered in the output buffer; preload
// transactions give no result. Throughput: one input bit per cycle while the
// buffer has room; in_tready is low during the zero-tail flush at a frame end.
// Reset: synchronous, clears the shift register, flush counter and output
// buffer and loads the default configuration.
// ----------------------------------------------------------------------------
module convolutional_encoder_top #(
  parameter int MAX_CONSTRAINT = ce_pkg::MAX_CONSTRAINT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ce_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ce_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ce_pkg::TDATA_W-1:0]    in_tdata,   // [0] data_bit, [7:1] zero
  input  logic                          in_tuser,   // [0] mode
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ce_pkg::TDATA_W-1:0]    out_tdata,  // [2:0] coded_bits, [7:3] zero
  output logic                          out_tlast
);

  localparam int         FW   = $clog2(MAX_CONSTRAINT);
  localparam logic [4:0] KMAX = 5'(MAX_CONSTRAINT);

  logic [1:0]                code_rate_r;
  logic [3:0]                constraint_length_r;
  logic                      tail_biting_r;
  logic [ce_pkg::POLY_W-1:0] poly_first_r;
  logic [ce_pkg::POLY_W-1:0] poly_second_r;
  logic [ce_pkg::POLY_W-1:0] poly_third_r;

  logic [FW-1:0] flush_cnt_r;
  logic [FW-1:0] flush_cnt_nxt;
  logic [FW-1:0] flush_len;
  logic [4:0]    k_ext;
  logic [4:0]    k_eff;

  logic                      flushing;
  logic                      buf_full;
  logic                      in_acc;
  logic                      flush_step;
  logic                      push;
  logic                      push_last;
  logic                      shift_bit;
  logic [ce_pkg::MAX_RATE-1:0] rate_mask;
  ce_pkg::cell_ctrl_t        ctrl;
  ce_pkg::out_item_t         push_item;
  ce_pkg::out_item_t         head_item;

  logic [ce_pkg::MAX_RATE-1:0][ce_pkg::POLY_W-1:0] polys;
  logic [MAX_CONSTRAINT-1:0]                       sr_q;
  logic [MAX_CONSTRAINT:0][ce_pkg::MAX_RATE-1:0]   par;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_rate_r         <= ce_pkg::RST_CODE_RATE;
      constraint_length_r <= ce_pkg::RST_CONSTRAINT;
      tail_biting_r       <= ce_pkg::RST_TAIL_BITING;
      poly_first_r        <= ce_pkg::RST_POLY_FIRST;
      poly_second_r       <= ce_pkg::RST_POLY_SECOND;
      poly_third_r        <= ce_pkg::RST_POLY_THIRD;
    end else if (cfg_we) begin
      case (cfg_addr)
        ce_pkg::REG_CODE_RATE:   code_rate_r         <= cfg_wdata[1:0];
        ce_pkg::REG_CONSTRAINT:  constraint_length_r <= cfg_wdata[3:0];
        ce_pkg::REG_TAIL_BITING: tail_biting_r       <= cfg_wdata[0];
        ce_pkg::REG_POLY_FIRST:  poly_first_r        <= cfg_wdata;
        ce_pkg::REG_POLY_SECOND: poly_second_r       <= cfg_wdata;
        ce_pkg::REG_POLY_THIRD:  poly_third_r        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign polys[0] = poly_first_r;
  assign polys[1] = poly_second_r;
  assign polys[2] = poly_third_r;

  assign k_ext     = {1'b0, constraint_length_r};
  assign k_eff     = (k_ext > KMAX) ? KMAX : k_ext;
  assign flush_len = (k_eff > 5'd1) ? FW'(k_eff - 5'd1) : '0;

  assign flushing   = (flush_cnt_r != '0);
  assign in_tready  = !flushing && !buf_full;
  assign in_acc     = in_tvalid && in_tready;
  assign flush_step = flushing && !buf_full;
  assign shift_bit  = flushing ? 1'b0 : in_tdata[0];
  assign push       = (in_acc && in_tuser) || flush_step;

  always_comb begin
    if (flush_step) begin
      push_last = (flush_cnt_r == FW'(1));
    end else begin
      push_last = in_tlast && (tail_biting_r || (flush_len == '0));
    end
  end

  assign ctrl.shift = in_acc || flush_step;
  assign ctrl.clear = push && push_last;

  always_comb begin
    flush_cnt_nxt = flush_cnt_r;
    if (in_acc && in_tuser && in_tlast && !tail_biting_r) begin
      flush_cnt_nxt = flush_len;
    end else if (flush_step) begin
      flush_cnt_nxt = flush_cnt_r - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flush_cnt_r <= '0;
    end else begin
      flush_cnt_r <= flush_cnt_nxt;
    end
  end

  assign par[0] = '0;

  for (genvar i = 0; i < MAX_CONSTRAINT; i++) begin : g_cell
    logic [ce_pkg::MAX_RATE-1:0] taps;
    logic                        d_in;

    for (genvar j = 0; j < ce_pkg::MAX_RATE; j++) begin : g_tap
      if (i < ce_pkg::POLY_W) begin : g_on
        assign taps[j] = polys[j][i];
      end else begin : g_off
        assign taps[j] = 1'b0;
      end
    end

    if (i == 0) begin : g_head
      assign d_in = shift_bit;
    end else begin : g_link
      assign d_in = sr_q[i-1];
    end

    ce_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .d_in    (d_in),
      .taps    (taps),
      .par_in  (par[i]),
      .par_out (par[i+1]),
      .q       (sr_q[i])
    );
  end

  always_comb begin
    for (int j = 0; j < ce_pkg::MAX_RATE; j++) begin
      rate_mask[j] = (int'(code_rate_r) > j);
    end
  end

  assign push_item.coded = par[MAX_CONSTRAINT] & rate_mask;
  assign push_item.last  = push_last;

  ce_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop_ready  (out_tready),
    .head_valid (out_tvalid),
    .head_item  (head_item),
    .full       (buf_full)
  );

  assign out_tdata = {{(ce_pkg::TDATA_W - ce_pkg::CODED_W){1'b0}}, head_item.coded};
  assign out_tlast = head_item.last;

endmodule

/* design/ce_cell.sv */
// ----------------------------------------------------------------------------
// Convolutional encoder cell
// One shift register bit plus its contribution to each parity chain.
// ----------------------------------------------------------------------------
module ce_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ce_pkg::cell_ctrl_t          ctrl,
  input  logic                        d_in,
  input  logic [ce_pkg::MAX_RATE-1:0] taps,
  input  logic [ce_pkg::MAX_RATE-1:0] par_in,
  output logic [ce_pkg::MAX_RATE-1:0] par_out,
  output logic                        q
);

  logic bit_r;
  logic bit_nxt;

  // parity is taken on the value after the shift
  assign par_out = par_in ^ ({ce_pkg::MAX_RATE{d_in}} & taps);
  assign q       = bit_r;

  always_comb begin
    bit_nxt = bit_r;
    if (ctrl.clear) begin
      bit_nxt = 1'b0;
    end else if (ctrl.shift) begin
      bit_nxt = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= 1'b0;
    end else begin
      bit_r <= bit_nxt;
    end
  end

endmodule

/* design/ce_out_buf.sv */
// ----------------------------------------------------------------------------
// Convolutional encoder output buffer
// Two-entry skid buffer between the encoder and the result stream.
// ----------------------------------------------------------------------------
module ce_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ce_pkg::out_item_t push_item,
  input  logic              pop_ready,
  output logic              head_valid,
  output ce_pkg::out_item_t head_item,
  output logic              full
);

  logic [1:0]        count_r;
  logic [1:0]        count_nxt;
  ce_pkg::out_item_t head_r;
  ce_pkg::out_item_t slot1_r;
  logic              pop;

  assign head_valid = (count_r != 2'd0);
  assign head_item  = head_r;
  assign full       = (count_r == 2'd2);
  assign pop        = head_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (count_r == 2'd2) begin
        head_r <= slot1_r;
        if (push) begin
          slot1_r <= push_item;
        end
      end else if (push) begin
        head_r <= push_item;
      end
    end else if (push) begin
      if (count_r == 2'd0) begin
        head_r <= push_item;
      end else begin
        slot1_r <= push_item;
      end
    end
  end

endmodule

/* design/ce_checker.sv */
// ----------------------------------------------------------------------------
// Convolutional encoder checker
// Port-level properties of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "convolutional_encoder_top_defines.svh"

module ce_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       in_tuser,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [ce_pkg::TDATA_W-1:0] out_tdata,
  input logic                       out_tlast
);

  `CE_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "output transaction changed while stalled")
  `CE_ASSERT_IMP(a_pad_zero, out_tvalid, out_tdata[ce_pkg::TDATA_W-1:ce_pkg::CODED_W] == '0, "output padding bits not zero")
  `CE_ASSERT_IMP(a_stall_cause, !in_tready, out_tvalid, "input stalled with no pending result")
  `CE_ASSERT_NXT(a_data_result, in_tvalid && in_tready && in_tuser && !out_tvalid, out_tvalid, "data transaction gave no result")

endmodule

bind convolutional_encoder_top ce_checker u_ce_checker (.*);

/* tb/tb_convolutional_encoder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Convolutional encoder testbench
// Drives directed and random bit streams through the encoder under changing
// rate, constraint length, polynomial and termination settings, with random
// stalls on both streams, and checks every coded result against a
// cycle-independent bit-level predictor.
// ----------------------------------------------------------------------------
module tb_convolutional_encoder_top;

  localparam bit MODE_PRELOAD = 1'b0;
  localparam bit MODE_DATA    = 1'b1;
  localparam int QUIET_LIMIT  = 2000;
  localparam int BIT_TARGET   = 320;
  localparam int SR_W         = ce_pkg::MAX_CONSTRAINT;
  localparam int CFG_W        = ce_pkg::CFG_DATA_W;
  localparam int PLY_W        = ce_pkg::POLY_W;
  localparam int TD_W         = ce_pkg::TDATA_W;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    ce_pkg::cfg_reg_t           addr;
    logic [CFG_W-1:0]           val;
    bit                         mode;
    bit                         d;
    bit                         fe;
    bit                         typed;
    logic [ce_pkg::CODED_W-1:0] ec;
    bit                         el;
  } dir_row_t;

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          cfg_we     = 1'b0;
  logic [ce_pkg::CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_W-1:0]              cfg_wdata  = '0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [TD_W-1:0]               in_tdata   = '0;
  logic                          in_tuser   = 1'b0;
  logic                          in_tlast   = 1'b0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [TD_W-1:0]               out_tdata;
  logic                          out_tlast;

  convolutional_encoder_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #10 clk = ~clk;

  // encoder shadow state and settings
  logic [1:0]       rate_cfg  = ce_pkg::RST_CODE_RATE;
  logic [3:0]       k_cfg     = ce_pkg::RST_CONSTRAINT;
  logic             tbite_cfg = ce_pkg::RST_TAIL_BITING;
  logic [PLY_W-1:0] poly_cfg [3];
  logic [SR_W-1:0]  enc_sr    = '0;

  ce_pkg::out_item_t coded_q [$];
  ce_pkg::out_item_t coded_exp;
  int                bits_sent      = 0;
  int                mismatches     = 0;
  int                quiet_cycles   = 0;
  bit                steady_in      = 1'b0;
  bit                steady_out     = 1'b0;
  bit                long_hold_done = 1'b0;
  bit                cfg_open       = 1'b0;

  dir_row_t dir_tab [30] = '{
    '{ROW_ITEM, ce_pkg::REG_CODE_RATE,   9'd0,   MODE_DATA,    1'b0, 1'b0, 1'b1, 3'd0, 1'b0},
    '{ROW_ITEM, ce_pkg::REG_CODE_RATE,   9'd0,   MODE_DATA,    1'b1, 1'b0, 1'b1, 3'd7, 1'b0},
    '{ROW_ITEM, ce_pkg::REG_CODE_RATE,   9'd0,   MODE_DATA,    1'b0, 1'b1, 1'b1, 3'd1, 1'b1},
    '{ROW_ITEM, ce_pkg::REG_CODE_RATE,   9'd0,   MODE_PRELOAD, 1'b1, 1'b1, 1'b0, 3'd0, 1'b0},
    '{ROW_ITEM, ce_pkg::REG_CODE_RATE,   9'd0,   MODE_PRELOAD, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0},
    '{ROW_ITEM, ce_pkg::REG_CODE_RATE,   9'd0,   MODE_PRELOAD, 1'b1, 1'b0, 1'b0, 3'd0, 1'b0},
    '{ROW_ITEM, ce_pkg::REG_CODE_RATE,   9'd0,   MODE_DATA,    1'b1, 1'b0, 1'b0, 3'd0, 1'b0},
    '{ROW_ITEM, ce_pkg::REG_CODE_RATE,   9'd0,   MODE_DATA,    1'b1, 1'b1, 1'b0, 3'd0, 1'b0},
    '{ROW_CFG,  ce_pkg::REG_TAIL_BITING, 9'd0,   MODE_DATA,    1'b0, 1'b0, 1'b0, 3'd0, 1'b0},
    '{ROW_CFG,  ce_pkg::REG_CONSTRAINT,  9'd9,   MODE_DATA,    1'b0, 1'b0, 1'b0, 3'd0, 1'b0},
    '{ROW_ITEM, ce_pkg::REG_CODE_RATE,   9'd0,   MODE_DATA,    1'b1, 1'b1, 1'b0, 3'd0, 1'b0},
    '{ROW_CFG,  ce_pkg::REG_CODE_RATE,   9'd0,   MODE_DATA,    1'b0, 1'b0, 1'b0, 3'd0, 1'b0},
    '{ROW_ITEM, ce_pkg::REG_CODE_RATE,   9'd0,   MODE_DATA,    1'b1, 1'b0, 1'b1, 3'd0, 1'b0},
    '{ROW_ITEM, ce_pkg::REG_CODE_RATE,   9'd0,   MODE_DATA,    1'b0, 1'b1, 1'b0, 3'd0, 1'b0},
    '{ROW_CFG,  ce_pkg::REG_CODE_RATE,   9'd1,   MODE_DATA,    1'b0, 1'b0, 1'b0, 3'd0, 1'b0},
    '{ROW_CFG,  ce_pkg::REG_POLY_FIRST,  9'd511, MODE_DATA,    1'b0, 1'b0, 1'b0, 3'd0, 1'b0},
    '{ROW_CFG,  ce_pkg::REG_POLY_SECOND, 9'd0,   MODE_DATA,    1'b0, 1'b0, 1'b0, 3'd0, 1'b0},
    '{ROW_CFG,  ce_pkg::REG_POLY_THIRD,  9'd511, MODE_DATA,    1'b0, 1'b0, 1'b0, 3'd0, 1'b0},
    '{ROW_CFG,  ce_pkg::REG_CONSTRAINT,  9'd15,  MODE_DATA,    1'b0, 1'b0, 1'b0, 3'd0, 1'b0},
    '{ROW_ITEM, ce_pkg::REG_CODE_RATE,   9'd0,   MODE_PRELOAD, 1'b1, 1'b0, 1'b0, 3'd0, 1'b0},
    '{ROW_ITEM, ce_pkg::REG_CODE_RATE,   9'd0,   MODE_DATA,    1'b1, 1'b1, 1'b0, 3'd0, 1'b0},
    '{ROW_CFG,  ce_pkg::REG_CONSTRAINT,  9'd0,   MODE_DATA,    1'b0, 1'b0, 1'b0, 3'd0, 1'b0},
    '{ROW_ITEM, ce_pkg::REG_CODE_RATE,   9'd0,   MODE_DATA,    1'b1, 1'b1, 1'b1, 3'd1, 1'b1},
    '{ROW_CFG,  ce_pkg::REG_CONSTRAINT,  9'd1,   MODE_DATA,    1'b0, 1'b0, 1'b0, 3'd0, 1'b0},
    '{ROW_ITEM, ce_pkg::REG_CODE_RATE,   9'd0,   MODE_DATA,    1'b0, 1'b1, 1'b1, 3'd0, 1'b1},
    '{ROW_CFG,  ce_pkg::REG_CODE_RATE,   9'd2,   MODE_DATA,    1'b0, 1'b0, 1'b0, 3'd0, 1'b0},
    '{ROW_CFG,  ce_pkg::REG_CONSTRAINT,  9'd2,   MODE_DATA,    1'b0, 1'b0, 1'b0, 3'd0, 1'b0},
    '{ROW_ITEM, ce_pkg::REG_CODE_RATE,   9'd0,   MODE_DATA,    1'b1, 1'b0, 1'b0, 3'd0, 1'b0},
    '{ROW_ITEM, ce_pkg::REG_CODE_RATE,   9'd0,   MODE_DATA,    1'b1, 1'b1, 1'b0, 3'd0, 1'b0},
    '{ROW_CFG,  ce_pkg::REG_TAIL_BITING, 9'd1,   MODE_DATA,    1'b0, 1'b0, 1'b0, 3'd0, 1'b0}
  };

  function automatic logic [ce_pkg::CODED_W-1:0] tap_parity();
    logic [ce_pkg::CODED_W-1:0] w;
    w = '0;
    for (int j = 0; j < ce_pkg::CODED_W; j++) begin
      if (j < rate_cfg) w[j] = ^(enc_sr & poly_cfg[j]);
    end
    return w;
  endfunction

  function automatic void encode_item(bit m, bit d, bit fe);
    int k;
    int flush;
    k = (k_cfg > SR_W) ? SR_W : k_cfg;
    flush = (k > 1) ? k - 1 : 0;
    enc_sr = {enc_sr[SR_W-2:0], d};
    if (m == MODE_PRELOAD) return;
    if (!fe) begin
      coded_q.push_back('{last: 1'b0, coded: tap_parity()});
      return;
    end
    if (tbite_cfg || flush == 0) begin
      coded_q.push_back('{last: 1'b1, coded: tap_parity()});
      enc_sr = '0;
      return;
    end
    coded_q.push_back('{last: 1'b0, coded: tap_parity()});
    for (int i = 0; i < flush; i++) begin
      enc_sr = {enc_sr[SR_W-2:0], 1'b0};
      coded_q.push_back('{last: (i == flush - 1), coded: tap_parity()});
    end
    enc_sr = '0;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_bit(input bit m, input bit d, input bit fe, input bit typed,
                          input logic [ce_pkg::CODED_W-1:0] ec, input bit el);
    int n0;
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= TD_W'(d);
    in_tlast  <= fe;
    do @(posedge clk); while (!in_tready);
    n0 = coded_q.size();
    encode_item(m, d, fe);
    if (typed) coded_q[n0] = '{last: el, coded: ec};
    bits_sent++;
    @(negedge clk);
    gap = steady_in ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (coded_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input ce_pkg::cfg_reg_t addr, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    case (addr)
      ce_pkg::REG_CODE_RATE:   rate_cfg    = val[1:0];
      ce_pkg::REG_CONSTRAINT:  k_cfg       = val[3:0];
      ce_pkg::REG_TAIL_BITING: tbite_cfg   = val[0];
      ce_pkg::REG_POLY_FIRST:  poly_cfg[0] = val;
      ce_pkg::REG_POLY_SECOND: poly_cfg[1] = val;
      ce_pkg::REG_POLY_THIRD:  poly_cfg[2] = val;
      default: ;
    endcase
    cfg_open = 1'b1;
    @(negedge clk);
  endtask

  function automatic logic [PLY_W-1:0] pick_poly();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PLY_W'($urandom_range(0, 511));
  endfunction

  task automatic shuffle_config();
    drain();
    cfg_write(ce_pkg::REG_CODE_RATE, CFG_W'($urandom_range(0, 3)));
    if ($urandom_range(0, 9) == 0)
      cfg_write(ce_pkg::REG_CONSTRAINT, CFG_W'($urandom_range(0, 15)));
    else
      cfg_write(ce_pkg::REG_CONSTRAINT, CFG_W'($urandom_range(2, 9)));
    cfg_write(ce_pkg::REG_TAIL_BITING, CFG_W'($urandom_range(0, 1)));
    cfg_write(ce_pkg::REG_POLY_FIRST, pick_poly());
    cfg_write(ce_pkg::REG_POLY_SECOND, pick_poly());
    cfg_write(ce_pkg::REG_POLY_THIRD, pick_poly());
    cfg_we   <= 1'b0;
    cfg_open = 1'b0;
  endtask

  task automatic random_frame();
    int r;
    int k;
    int n;
    r = $urandom_range(0, 9);
    k = (k_cfg > SR_W) ? SR_W : k_cfg;
    if (r < 8) begin
      if (tbite_cfg) begin
        repeat ((k > 1) ? k - 1 : 0)
          send_bit(MODE_PRELOAD, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'b0, '0, 1'b0);
      end
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
      for (int i = 0; i < n; i++)
        send_bit(MODE_DATA, 1'($urandom_range(0, 1)), (i == n - 1), 1'b0, '0, 1'b0);
    end else begin
      // broken sequence: arbitrary mix of preload and data transactions
      repeat ($urandom_range(1, 6))
        send_bit(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'b0, '0, 1'b0);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (coded_q.size() == 0) begin
        $error("unexpected result: coded_bits %0d last %0b",
               out_tdata[ce_pkg::CODED_W-1:0], out_tlast);
        mismatches++;
      end else begin
        coded_exp = coded_q.pop_front();
        if (out_tdata[ce_pkg::CODED_W-1:0] !== coded_exp.coded) begin
          $error("coded_bits: expected %0d, actual %0d", coded_exp.coded,
                 out_tdata[ce_pkg::CODED_W-1:0]);
          mismatches++;
        end
        if (out_tlast !== coded_exp.last) begin
          $error("last: expected %0b, actual %0b", coded_exp.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_convolutional_encoder_top: errors");
        $finish;
      end
    end
  end

  // result sink: random stalls, calm stretches, one long hold-off
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        if (!long_hold_done && bits_sent >= 100) begin
          hold = 150;
          long_hold_done = 1'b1;
        end else if ($urandom_range(0, 49) == 0) begin
          steady_out = !steady_out;
        end else if (!steady_out && $urandom_range(0, 3) == 0) begin
          hold = pick_gap();
        end
      end
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int phase;
    bit idle;
    poly_cfg[0] = ce_pkg::RST_POLY_FIRST;
    poly_cfg[1] = ce_pkg::RST_POLY_SECOND;
    poly_cfg[2] = ce_pkg::RST_POLY_THIRD;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    idle = 1'b1;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        if (!idle) drain();
        idle = 1'b1;
        cfg_write(dir_tab[i].addr, dir_tab[i].val);
      end else begin
        if (cfg_open) begin
          cfg_we   <= 1'b0;
          cfg_open = 1'b0;
        end
        idle = 1'b0;
        send_bit(dir_tab[i].mode, dir_tab[i].d, dir_tab[i].fe, dir_tab[i].typed,
                 dir_tab[i].ec, dir_tab[i].el);
      end
    end
    if (cfg_open) begin
      cfg_we   <= 1'b0;
      cfg_open = 1'b0;
    end

    phase = 0;
    while (bits_sent < BIT_TARGET) begin
      shuffle_config();
      steady_in = (phase % 3 == 2);
      repeat ($urandom_range(2, 5)) random_frame();
      phase++;
    end
    steady_in = 1'b0;

    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && coded_q.size() == 0)
      $display("tb_convolutional_encoder_top: clean");
    else
      $display("tb_convolutional_encoder_top: errors");
    $finish;
  end

endmodule
